// File: rtl/dda_pkg.sv
// ----------------------------------------------------------------------------
// dda_pkg: shared types and constants of the line rasteriser
// Default coordinate width, register codes, clip register widths and reset values, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dda_pkg;

  // default coordinate width of the grid
  localparam int unsigned COORD_BITS_DEF = 6;

  // clip registers
  localparam int unsigned CLIP_BITS = 6;
  localparam logic [CLIP_BITS-1:0] CLIP_X_RESET = 6'd32;
  localparam logic [CLIP_BITS-1:0] CLIP_Y_RESET = 6'd24;

  // configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_Y = 2'd1;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SETUP = 3'b010,
    ST_RUN   = 3'b100
  } state_t;

endpackage

`default_nettype wire

// File: rtl/dda_line_rasterizer.sv
// ----------------------------------------------------------------------------
// dda_line_rasterizer: exact DDA line stepping with clip flag
// Walks a segment from its first endpoint towards (not including) its second,
// one point per step, with quotient/remainder accumulators per axis.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_start_x/y, in_end_x/y
//  out      output     out_valid / out_ready  out_point_x/y, out_visible, out_last
//  cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A segment passes through the accept beat, a setup state that
//  forms steps = max(|dx|,|dy|), then one step of the accumulator unit per
//  point. A zero-length segment goes from setup back to idle, emitting nothing.
//  The accumulator unit advances only when the output register is free or
//  being taken, so a stall on out holds the walk. in_ready is high only idle.
//  Reset: clip_x = 32, clip_y = 24, sequencer idle, output register empty.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // segment beats
  input  wire                                    in_valid,
  output logic                                   in_ready,
  input  wire signed [COORD_BITS-1:0]            in_start_x,
  input  wire signed [COORD_BITS-1:0]            in_start_y,
  input  wire signed [COORD_BITS-1:0]            in_end_x,
  input  wire signed [COORD_BITS-1:0]            in_end_y,
  // point beats
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [COORD_BITS-1:0]           out_point_x,
  output logic signed [COORD_BITS-1:0]           out_point_y,
  output logic                                   out_visible,
  output logic                                   out_last,
  // register writes
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire [dda_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  wire [dda_pkg::CLIP_BITS-1:0]           cfg_data
);

  import dda_pkg::*;

  localparam int unsigned CMP_W = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

  // one accumulator step: value q + r/n advanced by d/n, |d| <= n
  function automatic logic [2*COORD_BITS-1:0] acc_step(
    input logic signed [COORD_BITS-1:0] q,
    input logic        [COORD_BITS-1:0] r,
    input logic signed [COORD_BITS:0]   d,
    input logic        [COORD_BITS-1:0] n
  );
    logic signed [COORD_BITS+1:0] sum;
    logic signed [COORD_BITS+1:0] n_ext;
    logic signed [COORD_BITS+1:0] r_n;
    logic signed [COORD_BITS-1:0] q_n;
    n_ext = $signed({2'b00, n});
    sum   = $signed({2'b00, r}) + $signed({d[COORD_BITS], d});
    q_n   = q;
    r_n   = sum;
    if (sum >= n_ext) begin
      r_n = sum - n_ext;
      q_n = q + COORD_BITS'(1);
    end else if (sum < 0) begin
      r_n = sum + n_ext;
      q_n = q - COORD_BITS'(1);
    end
    return {q_n, r_n[COORD_BITS-1:0]};
  endfunction

  // q + r/n truncated toward zero
  function automatic logic signed [COORD_BITS-1:0] trunc_val(
    input logic signed [COORD_BITS-1:0] q,
    input logic        [COORD_BITS-1:0] r
  );
    return (q[COORD_BITS-1] && (r != '0)) ? q + COORD_BITS'(1) : q;
  endfunction

  // magnitude, the most negative code reads as 2^(COORD_BITS-1)
  function automatic logic [COORD_BITS-1:0] mag(input logic signed [COORD_BITS-1:0] v);
    return v[COORD_BITS-1] ? (~v + COORD_BITS'(1)) : v;
  endfunction

  // delta magnitude, fits in COORD_BITS
  function automatic logic [COORD_BITS-1:0] dmag(input logic signed [COORD_BITS:0] v);
    logic [COORD_BITS:0] a;
    a = v[COORD_BITS] ? (~v + (COORD_BITS+1)'(1)) : v;
    return a[COORD_BITS-1:0];
  endfunction

  state_t state_r, state_nxt;

  logic [CLIP_BITS-1:0]          clip_x_r, clip_y_r;
  logic signed [COORD_BITS:0]    dx_r, dy_r;
  logic [COORD_BITS-1:0]         steps_r, steps_nxt;
  logic [COORD_BITS-1:0]         idx_r;
  logic signed [COORD_BITS-1:0]  qx_r, qy_r;
  logic [COORD_BITS-1:0]         rx_r, ry_r;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [COORD_BITS-1:0]  out_x_r, out_y_r;
  logic                          out_vis_r, out_last_r;

  logic                          in_beat;
  logic                          gen;
  logic                          is_last;
  logic signed [COORD_BITS-1:0]  px, py;
  logic                          vis;
  logic [2*COORD_BITS-1:0]       step_x, step_y;
  logic [COORD_BITS-1:0]         adx, ady;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_beat   = in_valid && in_ready;

  assign out_valid   = out_valid_r;
  assign out_point_x = out_x_r;
  assign out_point_y = out_y_r;
  assign out_visible = out_vis_r;
  assign out_last    = out_last_r;

  // setup: step count from the deltas
  assign adx       = dmag(dx_r);
  assign ady       = dmag(dy_r);
  assign steps_nxt = (adx > ady) ? adx : ady;

  // point generation and the per-axis accumulator steps
  assign gen     = (state_r == ST_RUN) && (!out_valid_r || out_ready);
  assign is_last = (idx_r == steps_r - COORD_BITS'(1));
  assign px      = trunc_val(qx_r, rx_r);
  assign py      = trunc_val(qy_r, ry_r);
  assign vis     = (CMP_W'(mag(px)) < CMP_W'(clip_x_r)) &&
                   (CMP_W'(mag(py)) < CMP_W'(clip_y_r));
  assign step_x  = acc_step(qx_r, rx_r, dx_r, steps_r);
  assign step_y  = acc_step(qy_r, ry_r, dy_r, steps_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_beat) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = (steps_nxt == '0) ? ST_IDLE : ST_RUN;
      ST_RUN:   if (gen && is_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // output register occupancy
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      clip_x_r    <= CLIP_X_RESET;
      clip_y_r    <= CLIP_Y_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CLIP_X) begin
          clip_x_r <= cfg_data;
        end else if (cfg_index == REG_CLIP_Y) begin
          clip_y_r <= cfg_data;
        end
      end
    end
  end

  // accumulators and walk counter
  always_ff @(posedge clk) begin
    if (in_beat) begin
      dx_r <= $signed({in_end_x[COORD_BITS-1], in_end_x}) -
              $signed({in_start_x[COORD_BITS-1], in_start_x});
      dy_r <= $signed({in_end_y[COORD_BITS-1], in_end_y}) -
              $signed({in_start_y[COORD_BITS-1], in_start_y});
      qx_r <= in_start_x;
      qy_r <= in_start_y;
      rx_r <= '0;
      ry_r <= '0;
    end else if (gen) begin
      qx_r <= step_x[2*COORD_BITS-1:COORD_BITS];
      rx_r <= step_x[COORD_BITS-1:0];
      qy_r <= step_y[2*COORD_BITS-1:COORD_BITS];
      ry_r <= step_y[COORD_BITS-1:0];
    end
    if (state_r == ST_SETUP) begin
      steps_r <= steps_nxt;
      idx_r   <= '0;
    end else if (gen) begin
      idx_r <= idx_r + COORD_BITS'(1);
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (gen) begin
      out_x_r    <= px;
      out_y_r    <= py;
      out_vis_r  <= vis;
      out_last_r <= is_last;
    end
  end

  // remainders stay below the step count while walking
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((rx_r < steps_r) && (ry_r < steps_r)))
    else $error("accumulator remainder out of range");

  // a walk never starts with zero steps nor runs past its count
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ((steps_r != '0) && (idx_r < steps_r)))
    else $error("walk counter out of range");

  // generating the final point returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (gen && is_last) |=> (state_r == ST_IDLE))
    else $error("sequencer did not return to idle after last point");

endmodule

`default_nettype wire

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the dda line rasteriser
// Segments go in on a valid/ready channel and the points that come back are
// checked against an exact integer walk of each segment kept in the bench,
// with clip settings changed between phases while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  import dda_pkg::*;

  localparam int unsigned CB = COORD_BITS_DEF;

  // index values that hit no register
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = 2'd3;

  localparam int unsigned MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 visible;
    logic                 last;
  } point_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  wire                         in_ready;
  logic signed [CB-1:0]        in_start_x = '0;
  logic signed [CB-1:0]        in_start_y = '0;
  logic signed [CB-1:0]        in_end_x = '0;
  logic signed [CB-1:0]        in_end_y = '0;
  wire                         out_valid;
  logic                        out_ready = 1'b0;
  wire signed [CB-1:0]         out_point_x;
  wire signed [CB-1:0]         out_point_y;
  wire                         out_visible;
  wire                         out_last;
  logic                        cfg_valid = 1'b0;
  wire                         cfg_ready;
  logic [CFG_IDX_BITS-1:0]     cfg_index = '0;
  logic [CLIP_BITS-1:0]        cfg_data = '0;

  // bench copy of the clip window
  int     clip_x_now = int'(CLIP_X_RESET);
  int     clip_y_now = int'(CLIP_Y_RESET);
  point_t expected_points[$];
  int     mismatch_count = 0;
  bit     steady_flow = 1'b0;

  always #2 clk = ~clk;

  dda_line_rasterizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_point_x(out_point_x),
    .out_point_y(out_point_y),
    .out_visible(out_visible),
    .out_last   (out_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // idle cycles before the next beat on either side
  function automatic int draw_gap();
    if (steady_flow) return 0;
    return $urandom_range(0, 17);
  endfunction

  // exact walk: point i is start + i*delta/steps, integer division truncating
  // toward zero, second endpoint left out
  function automatic void plot_segment(input logic signed [CB-1:0] sx, sy, ex, ey);
    int     x0, y0, dx, dy, adx, ady, steps, px, py;
    point_t p;
    x0 = sx;
    y0 = sy;
    dx = int'(ex) - x0;
    dy = int'(ey) - y0;
    adx = dx < 0 ? -dx : dx;
    ady = dy < 0 ? -dy : dy;
    steps = adx > ady ? adx : ady;
    for (int i = 0; i < steps; i++) begin
      px = (x0 * steps + i * dx) / steps;
      py = (y0 * steps + i * dy) / steps;
      p.x = px[CB-1:0];
      p.y = py[CB-1:0];
      p.visible = ((px < 0 ? -px : px) < clip_x_now) && ((py < 0 ? -py : py) < clip_y_now);
      p.last = (i == steps - 1);
      expected_points.push_back(p);
    end
  endfunction

  task automatic note_mismatch(input string what, input point_t want, input point_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN)
      $display("mismatch (%s): expected x=%0d y=%0d vis=%0b last=%0b,",
               what, want.x, want.y, want.visible, want.last,
               " got x=%0d y=%0d vis=%0b last=%0b",
               got.x, got.y, got.visible, got.last);
  endtask

  // one segment beat, held until taken, then its points are queued
  task automatic send_segment(input int sx, sy, ex, ey);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= sx[CB-1:0];
    in_start_y <= sy[CB-1:0];
    in_end_x   <= ex[CB-1:0];
    in_end_y   <= ey[CB-1:0];
    do @(posedge clk); while (!(in_valid && in_ready));
    plot_segment(in_start_x, in_start_y, in_end_x, in_end_y);
  endtask

  // one register beat; the caller drops cfg_valid after its last write
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CLIP_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    if (idx == REG_CLIP_X)
      clip_x_now = int'(data);
    else if (idx == REG_CLIP_Y)
      clip_y_now = int'(data);
  endtask

  task automatic program_clip(input logic [CLIP_BITS-1:0] cx, cy, input bit poke_spare);
    write_reg(REG_CLIP_X, cx);
    if (poke_spare) write_reg(REG_SPARE_A, CLIP_BITS'($urandom));
    write_reg(REG_CLIP_Y, cy);
    if (poke_spare) write_reg(REG_SPARE_B, CLIP_BITS'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // block idle: all points back, plus room for a trailing zero-length segment
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    if (v < -32) return -32;
    if (v > 31) return 31;
    return v;
  endfunction

  // mix of segment shapes: mostly random, with short, zero-length, axis-aligned and corner ones
  task automatic random_segments(input int count);
    int sx, sy, ex, ey;
    for (int n = 0; n < count; n++) begin
      sx = int'($urandom_range(0, 63)) - 32;
      sy = int'($urandom_range(0, 63)) - 32;
      ex = int'($urandom_range(0, 63)) - 32;
      ey = int'($urandom_range(0, 63)) - 32;
      case ($urandom_range(0, 9))
        5, 6: begin
          ex = clamp_coord(sx + int'($urandom_range(0, 10)) - 5);
          ey = clamp_coord(sy + int'($urandom_range(0, 10)) - 5);
        end
        7: begin
          ex = sx;
          ey = sy;
        end
        8: begin
          if ($urandom_range(0, 1)) ex = sx;
          else ey = sy;
        end
        9: begin
          sx = $urandom_range(0, 1) ? 31 : -32;
          sy = $urandom_range(0, 1) ? 31 : -32;
          ex = $urandom_range(0, 1) ? 31 : -32;
          ey = $urandom_range(0, 1) ? 31 : -32;
        end
        default: ;
      endcase
      send_segment(sx, sy, ex, ey);
    end
  endtask

  // directed shapes under the reset clip window
  task automatic test_directed_segments();
    send_segment(0, 0, 0, 0);
    send_segment(0, 0, 1, 0);
    send_segment(0, 0, 5, 2);
    send_segment(0, 0, 2, -5);
    send_segment(-32, -32, 31, 31);
    send_segment(31, -32, -32, 31);
    send_segment(-32, 0, 31, 0);
    send_segment(0, 31, 0, -32);
    send_segment(-5, -3, 5, 3);
    send_segment(3, -7, -4, 6);
    send_segment(-32, -32, -32, -32);
    send_segment(31, 31, 30, 30);
    send_segment(-1, -1, -8, -3);
    send_segment(23, 23, 25, 25);
    send_segment(-24, -23, -26, -25);
    send_segment(-32, 5, -31, 6);
    send_segment(10, -20, -10, 20);
  endtask

  // zero window, window past the grid, unit window, window at the grid edge
  task automatic test_clip_extremes();
    wait_drained();
    program_clip(6'd0, 6'd0, 1'b0);
    send_segment(-3, 2, 4, -1);
    send_segment(0, 0, 0, 2);
    wait_drained();
    program_clip(6'd63, 6'd63, 1'b1);
    send_segment(-32, 31, 31, -32);
    send_segment(-32, -32, -30, -31);
    wait_drained();
    program_clip(6'd1, 6'd1, 1'b0);
    send_segment(-2, -2, 2, 2);
    send_segment(1, 0, -1, 0);
    wait_drained();
    program_clip(6'd32, 6'd31, 1'b1);
    send_segment(-32, -31, -29, -28);
    send_segment(31, 29, 28, 32 - 1);
  endtask

  // phases of random segments, each under its own window
  task automatic test_random_traffic();
    logic [CLIP_BITS-1:0] cx, cy;
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      cx = CLIP_BITS'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(1, 32));
      cy = CLIP_BITS'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                : $urandom_range(1, 32));
      program_clip(cx, cy, 1'($urandom_range(0, 1)));
      steady_flow = (phase == 2) || (phase == 5);
      random_segments(58);
    end
    steady_flow = 1'b0;
  endtask

  // point sink with random stalls
  initial begin : point_sink
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // compare each point beat with the oldest expected point
  always @(posedge clk) begin : check_point
    point_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{x: out_point_x, y: out_point_y, visible: out_visible, last: out_last};
      if (expected_points.size() == 0) begin
        note_mismatch("point with none expected", '0, got);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x || got.y !== want.y ||
            got.visible !== want.visible || got.last !== want.last)
          note_mismatch("wrong point", want, got);
      end
    end
  end

  // overall limit on the run
  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_segments();
    test_clip_extremes();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
